// ----- hw/rtl/bsru_pkg.sv -----
`default_nettype none
package bsru_pkg;

  // Default geometry and fraction precision
  localparam int unsigned DEF_MAX_WIDTH  = 256;
  localparam int unsigned DEF_MAX_HEIGHT = 256;
  localparam int unsigned DEF_FRAC_BITS  = 8;

  // Pixel format
  localparam int unsigned PIX_W = 24;
  localparam int unsigned CH_W  = 8;

  // Configuration registers
  localparam int unsigned CFG_W   = 9;
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;
  localparam logic [CFG_W-1:0] DIM_RESET = 9'd256;

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_t;

  // Item commands
  typedef enum logic {
    CMD_WRITE  = 1'b0,
    CMD_SAMPLE = 1'b1
  } cmd_t;

endpackage
`default_nettype wire

// ----- hw/rtl/bsru_ram.sv -----
`default_nettype none
module bsru_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

// ----- hw/rtl/bilinear_rgb_sampler_unit.sv -----
`default_nettype none
// Channel   | Direction | Handshake                 | Payload
// ----------+-----------+---------------------------+-------------------------------------
// input     | in        | in_valid / in_ready       | cmd, coord_x, coord_y, frac_x,
//           |           |                           | frac_y, write_pixel
// result    | out       | out_valid / out_ready     | red, green, blue
// config    | in/out    | APB psel/penable/pready   | image_width @0x0, image_height @0x4
//
// Sequencing: a pixel write is stored at the accepting edge. A sample
// holds off the next item until its result is loaded: four neighbor reads on the
// single pixel store port, one per cycle, feed a shared three-lane
// multiply-accumulate; the last product is added in the FIN state.
// Reset clears the sequencer and result valid and sets the size registers to 256x256.
// The pixel store is not cleared. A stalled result holds the sum in a hold
// state; the block takes no new transfer until the result register is free.
module bilinear_rgb_sampler_unit #(
  parameter int unsigned MAX_WIDTH  = bsru_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = bsru_pkg::DEF_MAX_HEIGHT,
  parameter int unsigned FRAC_BITS  = bsru_pkg::DEF_FRAC_BITS
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // APB configuration port
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [bsru_pkg::PADDR_W-1:0] paddr,
  input  wire logic [bsru_pkg::PDATA_W-1:0] pwdata,
  output logic      [bsru_pkg::PDATA_W-1:0] prdata,
  output logic                              pready,
  // input items
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic                         cmd,
  input  wire logic [7:0]                   coord_x,
  input  wire logic [7:0]                   coord_y,
  input  wire logic [7:0]                   frac_x,
  input  wire logic [7:0]                   frac_y,
  input  wire logic [23:0]                  write_pixel,
  // results
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic      [7:0]                   red,
  output logic      [7:0]                   green,
  output logic      [7:0]                   blue
);

  import bsru_pkg::*;

  // Dimension compare width: holds the 9-bit register and MAX
  localparam int unsigned XDW = ($clog2(MAX_WIDTH + 1) > CFG_W) ?
                                $clog2(MAX_WIDTH + 1) : CFG_W;
  localparam int unsigned YDW = ($clog2(MAX_HEIGHT + 1) > CFG_W) ?
                                $clog2(MAX_HEIGHT + 1) : CFG_W;
  // Column / row index widths
  localparam int unsigned XAW = $clog2(MAX_WIDTH);
  localparam int unsigned YAW = $clog2(MAX_HEIGHT);
  localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW  = $clog2(DEPTH);
  // Fixed-point widths
  localparam int unsigned SW    = FRAC_BITS + 1;       // S - f, f
  localparam int unsigned WGT_W = 2 * FRAC_BITS + 1;   // product of two factors
  localparam int unsigned ACC_W = 2 * FRAC_BITS + CH_W;
  localparam logic [SW-1:0] SCALE = SW'(1) << FRAC_BITS;
  localparam logic [XDW-1:0] MAXW = XDW'(MAX_WIDTH);
  localparam logic [YDW-1:0] MAXH = YDW'(MAX_HEIGHT);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_FIN,
    ST_HOLD
  } state_t;

  state_t state;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0] image_width;
  logic [CFG_W-1:0] image_height;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= DIM_RESET;
      image_height <= DIM_RESET;
    end else if (cfg_wr) begin
      unique case (reg_idx_t'(paddr[2]))
        REG_WIDTH:  image_width  <= pwdata[CFG_W-1:0];
        REG_HEIGHT: image_height <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_t'(paddr[2]))
      REG_WIDTH:  prdata = PDATA_W'(image_width);
      REG_HEIGHT: prdata = PDATA_W'(image_height);
      default:    prdata = '0;
    endcase
  end

  // Effective image size: zero acts as one, oversize clamps to the store
  logic [XDW-1:0] w_eff;
  logic [YDW-1:0] h_eff;

  always_comb begin
    if (image_width == '0) begin
      w_eff = XDW'(1);
    end else if (XDW'(image_width) > MAXW) begin
      w_eff = MAXW;
    end else begin
      w_eff = XDW'(image_width);
    end
    if (image_height == '0) begin
      h_eff = YDW'(1);
    end else if (YDW'(image_height) > MAXH) begin
      h_eff = MAXH;
    end else begin
      h_eff = YDW'(image_height);
    end
  end

  // ---------------------------------------------------------------------------
  // Item decode (IDLE only)
  // ---------------------------------------------------------------------------
  logic [XDW-1:0] cx_ext;
  logic [YDW-1:0] cy_ext;
  logic           x_in;
  logic           y_in;
  logic [XDW-1:0] x0_c;
  logic [XDW-1:0] x1_c;
  logic [YDW-1:0] y0_c;
  logic [YDW-1:0] y1_c;
  logic [FRAC_BITS-1:0] fx_c;
  logic [FRAC_BITS-1:0] fy_c;
  logic           accept;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  assign cx_ext = XDW'(coord_x);
  assign cy_ext = YDW'(coord_y);
  assign x_in   = cx_ext < w_eff;
  assign y_in   = cy_ext < h_eff;

  // Sample point clamped into the image, right/lower neighbor clamped too
  assign x0_c = x_in ? cx_ext : w_eff - XDW'(1);
  assign y0_c = y_in ? cy_ext : h_eff - YDW'(1);
  assign x1_c = (x0_c + XDW'(1) < w_eff) ? x0_c + XDW'(1) : w_eff - XDW'(1);
  assign y1_c = (y0_c + YDW'(1) < h_eff) ? y0_c + YDW'(1) : h_eff - YDW'(1);

  // Keep only the low FRAC_BITS of the fraction (zero-extend if wider)
  assign fx_c = FRAC_BITS'({{FRAC_BITS{1'b0}}, frac_x});
  assign fy_c = FRAC_BITS'({{FRAC_BITS{1'b0}}, frac_y});

  // ---------------------------------------------------------------------------
  // Sample context and sequencer datapath
  // ---------------------------------------------------------------------------
  logic [XAW-1:0] x0, x1;
  logic [YAW-1:0] y0, y1;
  logic [SW-1:0]  fx, fy, sfx, sfy;
  logic [1:0]     idx;
  logic [WGT_W-1:0] wgt;
  logic [ACC_W-1:0] acc_r, acc_g, acc_b;

  // Neighbor order: idx[0] picks the right column, idx[1] the lower row
  logic [XAW-1:0] rd_x;
  logic [YAW-1:0] rd_y;
  logic [SW-1:0]  fac_a;
  logic [SW-1:0]  fac_b;

  assign rd_x  = idx[0] ? x1 : x0;
  assign rd_y  = idx[1] ? y1 : y0;
  assign fac_a = idx[0] ? fx : sfx;
  assign fac_b = idx[1] ? fy : sfy;

  // Pixel store port
  logic           ram_we;
  logic [AW-1:0]  ram_addr;
  logic [PIX_W-1:0] ram_rdata;

  assign ram_we = accept && (cmd_t'(cmd) == CMD_WRITE) && x_in && y_in;

  always_comb begin
    if (state == ST_IDLE) begin
      ram_addr = AW'(YAW'(coord_y)) * AW'(MAX_WIDTH) + AW'(XAW'(coord_x));
    end else begin
      ram_addr = AW'(rd_y) * AW'(MAX_WIDTH) + AW'(rd_x);
    end
  end

  bsru_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (write_pixel),
    .rdata (ram_rdata)
  );

  // Shared three-lane MAC: pixel from the previous read times its weight
  logic [ACC_W-1:0] mac_r, mac_g, mac_b;
  logic [ACC_W-1:0] sum_r, sum_g, sum_b;

  assign mac_r = ACC_W'(ram_rdata[23:16] * wgt);
  assign mac_g = ACC_W'(ram_rdata[15:8]  * wgt);
  assign mac_b = ACC_W'(ram_rdata[7:0]   * wgt);
  assign sum_r = acc_r + mac_r;
  assign sum_g = acc_g + mac_g;
  assign sum_b = acc_b + mac_b;

  logic out_free;
  logic out_load;
  assign out_free = !out_valid || out_ready;
  // result register takes a finished sum this cycle
  assign out_load = ((state == ST_FIN) || (state == ST_HOLD)) && out_free;

  // ---------------------------------------------------------------------------
  // Sequencer and result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept && (cmd_t'(cmd) == CMD_SAMPLE)) begin
            x0    <= XAW'(x0_c);
            x1    <= XAW'(x1_c);
            y0    <= YAW'(y0_c);
            y1    <= YAW'(y1_c);
            fx    <= SW'(fx_c);
            fy    <= SW'(fy_c);
            sfx   <= SCALE - SW'(fx_c);
            sfy   <= SCALE - SW'(fy_c);
            idx   <= '0;
            state <= ST_READ;
          end
        end
        ST_READ: begin
          // read issued this cycle; weight for it registered alongside
          wgt <= WGT_W'(fac_a * fac_b);
          if (idx == 2'd0) begin
            acc_r <= '0;
            acc_g <= '0;
            acc_b <= '0;
          end else begin
            acc_r <= sum_r;
            acc_g <= sum_g;
            acc_b <= sum_b;
          end
          idx <= idx + 2'd1;
          if (idx == 2'd3) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          // last neighbor accumulates here
          if (out_free) begin
            red       <= sum_r[ACC_W-1 -: CH_W];
            green     <= sum_g[ACC_W-1 -: CH_W];
            blue      <= sum_b[ACC_W-1 -: CH_W];
            state     <= ST_IDLE;
          end else begin
            acc_r <= sum_r;
            acc_g <= sum_g;
            acc_b <= sum_b;
            state <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (out_free) begin
            red       <= acc_r[ACC_W-1 -: CH_W];
            green     <= acc_g[ACC_W-1 -: CH_W];
            blue      <= acc_b[ACC_W-1 -: CH_W];
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import bsru_pkg::*;

  // Mirror of the pixel store and the size registers. Every accepted item is
  // applied here in transfer order; each sample queues its expected color.
  class image_mirror;
    logic [23:0] pixels [65536];
    bit          written [65536];
    int unsigned cols;
    int unsigned rows;
    int unsigned failures;
    logic [23:0] expected_rgb [$];

    function new();
      cols     = 256;
      rows     = 256;
      failures = 0;
    endfunction

    // 0 behaves as 1, anything above 256 as 256
    function void set_dim(reg_idx_t idx, logic [8:0] raw);
      int unsigned eff;
      eff = (raw == 0) ? 1 : (raw > 256) ? 256 : raw;
      if (idx == REG_WIDTH) cols = eff;
      else rows = eff;
    endfunction

    // Store addresses of the four neighbors after edge clamping
    function void corners(input logic [7:0] x, input logic [7:0] y,
                          output logic [15:0] a00, output logic [15:0] a10,
                          output logic [15:0] a01, output logic [15:0] a11);
      int unsigned x0, y0, x1, y1;
      x0 = (x < cols) ? x : cols - 1;
      y0 = (y < rows) ? y : rows - 1;
      x1 = (x0 + 1 < cols) ? x0 + 1 : cols - 1;
      y1 = (y0 + 1 < rows) ? y0 + 1 : rows - 1;
      a00 = {y0[7:0], x0[7:0]};
      a10 = {y0[7:0], x1[7:0]};
      a01 = {y1[7:0], x0[7:0]};
      a11 = {y1[7:0], x1[7:0]};
    endfunction

    // Returns 1 and a never-written neighbor if the sample is not yet legal
    function bit find_gap(input logic [7:0] x, input logic [7:0] y,
                          output logic [15:0] hole);
      logic [15:0] a [4];
      corners(x, y, a[0], a[1], a[2], a[3]);
      hole = '0;
      find_gap = 1'b0;
      for (int k = 0; k < 4; k++) begin
        if (!written[a[k]]) begin
          hole = a[k];
          find_gap = 1'b1;
        end
      end
    endfunction

    // Exact weighted sum per lane, floor of sum / 2^16
    function logic [23:0] blend(logic [7:0] x, logic [7:0] y,
                                logic [7:0] fx, logic [7:0] fy);
      logic [15:0] a [4];
      int unsigned wt [4];
      int unsigned fxi, fyi, sum;
      logic [23:0] rgb;
      corners(x, y, a[0], a[1], a[2], a[3]);
      fxi = fx;
      fyi = fy;
      wt[0] = (256 - fxi) * (256 - fyi);
      wt[1] = fxi * (256 - fyi);
      wt[2] = (256 - fxi) * fyi;
      wt[3] = fxi * fyi;
      for (int lane = 0; lane < 3; lane++) begin
        sum = 0;
        for (int k = 0; k < 4; k++) sum += pixels[a[k]][lane*8 +: 8] * wt[k];
        rgb[lane*8 +: 8] = 8'(sum >> 16);
      end
      return rgb;
    endfunction

    function void note_item(cmd_t c, logic [7:0] x, logic [7:0] y,
                            logic [7:0] fx, logic [7:0] fy, logic [23:0] pix);
      if (c == CMD_WRITE) begin
        // writes outside the active image are dropped
        if (x < cols && y < rows) begin
          pixels[{y, x}]  = pix;
          written[{y, x}] = 1'b1;
        end
      end else begin
        expected_rgb.insert(expected_rgb.size(), blend(x, y, fx, fy));
      end
    endfunction

    function void check_rgb(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      logic [23:0] want, got;
      string lane_name [3];
      lane_name = '{"blue", "green", "red"};
      got = {r, g, b};
      if (expected_rgb.size() == 0) begin
        $error("result with no sample pending: red %0d green %0d blue %0d", r, g, b);
        failures++;
        return;
      end
      want = expected_rgb.pop_front();
      for (int k = 0; k < 3; k++) begin
        if (got[k*8 +: 8] !== want[k*8 +: 8]) begin
          $error("%s: expected %0d, actual %0d", lane_name[k], want[k*8 +: 8],
                 got[k*8 +: 8]);
          failures++;
        end
      end
    endfunction
  endclass

  // Clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  // APB side
  logic               psel    = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite  = 1'b0;
  logic [PADDR_W-1:0] paddr   = '0;
  logic [PDATA_W-1:0] pwdata  = '0;
  wire  [PDATA_W-1:0] prdata;
  wire                pready;

  // Item channel
  logic        in_valid    = 1'b0;
  wire         in_ready;
  cmd_t        cmd         = CMD_WRITE;
  logic [7:0]  coord_x     = '0;
  logic [7:0]  coord_y     = '0;
  logic [7:0]  frac_x      = '0;
  logic [7:0]  frac_y      = '0;
  logic [23:0] write_pixel = '0;

  // Result channel
  wire        out_valid;
  logic       out_ready = 1'b0;
  wire  [7:0] red;
  wire  [7:0] green;
  wire  [7:0] blue;

  // High during the stretch where neither side idles
  bit steady = 1'b0;

  image_mirror book;

  bilinear_rgb_sampler_unit uut (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .cmd         (cmd),
    .coord_x     (coord_x),
    .coord_y     (coord_y),
    .frac_x      (frac_x),
    .frac_y      (frac_y),
    .write_pixel (write_pixel),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .red         (red),
    .green       (green),
    .blue        (blue)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Result side back-pressure: stalls in roughly 38% of cycles, never while steady
  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= 38);
  end

  // Every result transfer is checked against the oldest pending sample
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) book.check_rgb(red, green, blue);
  end

  // One item transfer; valid stays up until in_ready is seen at an edge.
  // Optionally drops valid for a short random gap afterwards.
  task automatic send_item(cmd_t c, logic [7:0] x, logic [7:0] y,
                           logic [7:0] fx, logic [7:0] fy, logic [23:0] pix);
    cmd         <= c;
    coord_x     <= x;
    coord_y     <= y;
    frac_x      <= fx;
    frac_y      <= fy;
    write_pixel <= pix;
    in_valid    <= 1'b1;
    do @(posedge clk); while (!in_ready);
    book.note_item(c, x, y, fx, fy, pix);
    if (!steady && $urandom_range(99) < 38) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  // Drop valid, let every pending sample come back, then allow for a write
  // or sample still in flight before touching registers.
  task automatic settle();
    int unsigned spins;
    spins = 0;
    in_valid <= 1'b0;
    while (book.expected_rgb.size() != 0 && spins < 50000) begin
      @(posedge clk);
      spins++;
    end
    repeat (10) @(posedge clk);
  endtask

  // APB write: setup cycle, then access until pready
  task automatic write_reg(reg_idx_t idx, logic [8:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= PDATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    book.set_dim(idx, value);
  endtask

  task automatic set_size(logic [8:0] w, logic [8:0] h);
    settle();
    write_reg(REG_WIDTH, w);
    @(posedge clk);
    write_reg(REG_HEIGHT, h);
  endtask

  // Write coordinates: mostly the phase window, some at/just past the
  // edge, some anywhere (often outside, so dropped)
  function automatic logic [7:0] pick_write(int unsigned lim, int unsigned org);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return 8'(org + $urandom_range(3));
    if (r < 85) return (lim < 256) ? 8'(lim - 1 + $urandom_range(1)) : 8'd255;
    return 8'($urandom_range(255));
  endfunction

  // Sample coordinates: window, near or past the far edge, or anywhere
  function automatic logic [7:0] pick_sample(int unsigned lim, int unsigned org);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return 8'(org + $urandom_range(3));
    if (r < 85) return 8'($urandom_range((lim >= 2) ? lim - 2 : 0, 255));
    return 8'($urandom_range(255));
  endfunction

  // Random traffic under the current size. A sample whose neighbors are not
  // all written is turned into a write of the missing pixel, so the window
  // fills up and later samples go through. Dropped writes are not counted.
  task automatic run_phase(int unsigned target);
    int unsigned done, ox, oy;
    logic [7:0]  x, y;
    logic [15:0] hole;
    done = 0;
    ox = (book.cols > 4) ? $urandom_range(book.cols - 4) : 0;
    oy = (book.rows > 4) ? $urandom_range(book.rows - 4) : 0;
    while (done < target) begin
      if ($urandom_range(99) < 40) begin
        x = pick_write(book.cols, ox);
        y = pick_write(book.rows, oy);
        if (x < book.cols && y < book.rows) done++;
        send_item(CMD_WRITE, x, y, 8'($urandom()), 8'($urandom()), 24'($urandom()));
      end else begin
        x = pick_sample(book.cols, ox);
        y = pick_sample(book.rows, oy);
        if (book.find_gap(x, y, hole))
          send_item(CMD_WRITE, hole[7:0], hole[15:8], 8'($urandom()), 8'($urandom()),
                    24'($urandom()));
        else
          send_item(CMD_SAMPLE, x, y, 8'($urandom()), 8'($urandom()), 24'($urandom()));
        done++;
      end
    end
  endtask

  initial begin
    int unsigned phase_w [10];
    int unsigned phase_h [10];
    book = new();
    // extremes, single row/column, tiny images, out-of-range register values
    phase_w = '{256, 1, 1, 256, 2, 3, 17, 511, 0, 0};
    phase_h = '{256, 1, 256, 1, 2, 5, 9, 0, 0, 0};
    phase_w[8] = $urandom_range(1, 300);
    phase_h[8] = $urandom_range(1, 300);
    phase_w[9] = $urandom_range(1, 300);
    phase_h[9] = $urandom_range(1, 300);

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed, reset size 256x256: a 2x2 block at the origin
    send_item(CMD_WRITE, 8'd0, 8'd0, 8'd0, 8'd0, 24'hFFFFFF);
    send_item(CMD_WRITE, 8'd1, 8'd0, 8'd255, 8'd255, 24'h000000);
    send_item(CMD_WRITE, 8'd0, 8'd1, 8'd0, 8'd0, 24'hA5C35A);
    send_item(CMD_WRITE, 8'd1, 8'd1, 8'd0, 8'd0, 24'h123456);
    send_item(CMD_SAMPLE, 8'd0, 8'd0, 8'd0, 8'd0, 24'h000000);
    send_item(CMD_SAMPLE, 8'd0, 8'd0, 8'd255, 8'd0, 24'hFFFFFF);
    send_item(CMD_SAMPLE, 8'd0, 8'd0, 8'd0, 8'd255, 24'h000000);
    send_item(CMD_SAMPLE, 8'd0, 8'd0, 8'd255, 8'd255, 24'h000000);
    send_item(CMD_SAMPLE, 8'd0, 8'd0, 8'd128, 8'd128, 24'h000000);
    // far corner: right and lower neighbors clamp to the last column/row
    send_item(CMD_WRITE, 8'd255, 8'd255, 8'd0, 8'd0, 24'hFFFFFF);
    send_item(CMD_WRITE, 8'd254, 8'd255, 8'd0, 8'd0, 24'h000000);
    send_item(CMD_WRITE, 8'd255, 8'd254, 8'd0, 8'd0, 24'h800080);
    send_item(CMD_WRITE, 8'd254, 8'd254, 8'd0, 8'd0, 24'h7F7F7F);
    send_item(CMD_SAMPLE, 8'd255, 8'd255, 8'd255, 8'd255, 24'h000000);
    send_item(CMD_SAMPLE, 8'd254, 8'd254, 8'd255, 8'd255, 24'h000000);
    send_item(CMD_SAMPLE, 8'd254, 8'd255, 8'd200, 8'd77, 24'h000000);

    // Zero sizes act as a single pixel; points beyond clamp onto it
    set_size(9'd0, 9'd0);
    send_item(CMD_SAMPLE, 8'd0, 8'd0, 8'd255, 8'd255, 24'h000000);
    send_item(CMD_SAMPLE, 8'd255, 8'd255, 8'd17, 8'd200, 24'h000000);
    send_item(CMD_WRITE, 8'd5, 8'd5, 8'd0, 8'd0, 24'h123456);
    send_item(CMD_WRITE, 8'd0, 8'd0, 8'd0, 8'd0, 24'h00FF80);
    send_item(CMD_SAMPLE, 8'd3, 8'd9, 8'd99, 8'd1, 24'h000000);

    // Oversized values act as 256
    set_size(9'd257, 9'd511);
    send_item(CMD_SAMPLE, 8'd0, 8'd0, 8'd64, 8'd192, 24'h000000);

    // Random phases; phase 3 runs with no idling on either side
    for (int p = 0; p < 10; p++) begin
      set_size(9'(phase_w[p]), 9'(phase_h[p]));
      steady = (p == 3);
      run_phase(64);
    end
    steady = 1'b0;

    settle();
    if (book.expected_rgb.size() != 0) begin
      $error("%0d samples never produced a result", book.expected_rgb.size());
      book.failures++;
    end
    if (book.failures == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #4000000;
    $display("Verification failed");
    $finish;
  end

endmodule
